// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file ttw_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TTW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ttw_pkg.sv -----
// Types, constants and helper functions for the translation table walk classifier.
// No dependencies; every other file in this block but assert_macros.svh uses it.
package ttw_pkg;

   localparam int ADDR_W        = 48;
   localparam int ADDRESS_BITS  = 48;
   localparam int DESC_W        = 64;
   localparam int LEVEL_W       = 2;
   localparam int INDEX_W       = 9;
   localparam int ENTRY_SHIFT   = 3;
   localparam int PAGE_SHIFT    = 12;
   localparam int TOP_SHIFT     = 39;
   localparam int LEVEL_STRIDE  = 9;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 48;
   localparam int GRANULE_W     = 2;
   localparam int SIZE_OFFSET_W = 6;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

   localparam logic [ADDR_W-1:0] PA_MASK = (ADDRESS_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
                                           ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);
   localparam logic [ADDR_W-1:0] BASE_MASK  = 48'hffff_ffff_fffe;
   localparam logic [ADDR_W-1:0] OA_MASK    = 48'hffff_ffff_f000;
   localparam logic [ADDR_W-1:0] WALK_LIMIT = 48'h7fff_ffff_ffff;
   localparam logic [SIZE_OFFSET_W-1:0] SIZE_OFFSET_LIMIT = 6'd25;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL  = 2'd0;
   localparam logic [LEVEL_W-1:0] LAST_LEVEL = 2'd3;

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_DESC  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_FETCH = 2'd0,
      KIND_RANGE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_UNMAPPED     = 2'd0,
      CLASS_NON_IDENTITY = 2'd1,
      CLASS_IDENTITY     = 2'd2
   } class_type;

   typedef enum logic [1:0] {
      ERR_NONE        = 2'd0,
      ERR_GRANULE     = 2'd1,
      ERR_SIZE_OFFSET = 2'd2
   } err_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TABLE_BASE  = 2'd0,
      CSR_GRANULE     = 2'd1,
      CSR_SIZE_OFFSET = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      DESC_INVALID0 = 2'd0,
      DESC_BLOCK    = 2'd1,
      DESC_INVALID2 = 2'd2,
      DESC_TABLE    = 2'd3
   } desc_low_type;

   localparam logic [GRANULE_W-1:0] GRANULE_4K = 2'd0;

   typedef struct packed {
      logic [ADDR_W-1:0]        table_base;
      logic [GRANULE_W-1:0]     granule;
      logic [SIZE_OFFSET_W-1:0] size_offset;
   } cfg_type;

   typedef struct packed {
      logic              cmd;
      logic [DESC_W-1:0] descriptor;
   } item_type;

   typedef struct packed {
      kind_type          kind;
      logic [ADDR_W-1:0] fetch_address;
      logic [ADDR_W-1:0] range_start;
      logic [ADDR_W-1:0] range_end;
      class_type         range_class;
      err_type           error_code;
      logic              walk_done;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    first_valid;
      logic    second_valid;
      rsp_type first;
      rsp_type second;
   } push_type;

   function automatic logic [INDEX_W-1:0] fetch_index(input logic [ADDR_W-1:0] addr,
                                                      input logic [LEVEL_W-1:0] level);
      logic [INDEX_W-1:0] idx;
      unique case (level)
         2'd0:    idx = addr[TOP_SHIFT +: INDEX_W];
         2'd1:    idx = addr[TOP_SHIFT - LEVEL_STRIDE +: INDEX_W];
         2'd2:    idx = addr[TOP_SHIFT - 2 * LEVEL_STRIDE +: INDEX_W];
         default: idx = addr[TOP_SHIFT - 3 * LEVEL_STRIDE +: INDEX_W];
      endcase
      return idx;
   endfunction

   function automatic logic [ADDR_W-1:0] level_step(input logic [LEVEL_W-1:0] level);
      logic [ADDR_W-1:0] step;
      unique case (level)
         2'd0:    step = ADDR_W'(1) << TOP_SHIFT;
         2'd1:    step = ADDR_W'(1) << (TOP_SHIFT - LEVEL_STRIDE);
         2'd2:    step = ADDR_W'(1) << (TOP_SHIFT - 2 * LEVEL_STRIDE);
         default: step = ADDR_W'(1) << (TOP_SHIFT - 3 * LEVEL_STRIDE);
      endcase
      return step;
   endfunction

   function automatic rsp_type make_fetch(input logic [ADDR_W-1:0] table_addr,
                                          input logic [ADDR_W-1:0] addr,
                                          input logic [LEVEL_W-1:0] level);
      rsp_type r;
      r = '0;
      r.kind = KIND_FETCH;
      r.fetch_address = table_addr +
                        ADDR_W'({fetch_index(addr, level), {ENTRY_SHIFT{1'b0}}});
      return r;
   endfunction

   function automatic rsp_type make_range(input logic [ADDR_W-1:0] start_addr,
                                          input logic [ADDR_W-1:0] end_addr,
                                          input class_type cls,
                                          input logic done);
      rsp_type r;
      r = '0;
      r.kind = KIND_RANGE;
      r.range_start = start_addr;
      r.range_end = end_addr;
      r.range_class = cls;
      r.walk_done = done;
      return r;
   endfunction

   function automatic rsp_type make_error(input err_type code);
      rsp_type r;
      r = '0;
      r.kind = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

endpackage

// ----- design/ttw_if.sv -----
// Valid/ready channel interfaces: request, response and register write.
// Depends on ttw_pkg for widths.
interface ttw_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [ttw_pkg::DESC_W-1:0] descriptor;

   modport source (output valid, cmd, descriptor, input ready);
   modport sink (input valid, cmd, descriptor, output ready);
endinterface

interface ttw_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                kind;
   logic [ttw_pkg::ADDR_W-1:0] fetch_address;
   logic [ttw_pkg::ADDR_W-1:0] range_start;
   logic [ttw_pkg::ADDR_W-1:0] range_end;
   logic [1:0]                range_class;
   logic [1:0]                error_code;
   logic                      walk_done;
   logic                      last;

   modport source (output valid, kind, fetch_address, range_start, range_end, range_class,
                   error_code, walk_done, last, input ready);
   modport sink (input valid, kind, fetch_address, range_start, range_end, range_class,
                 error_code, walk_done, last, output ready);
endinterface

interface ttw_csr_if;
   logic                           valid;
   logic                           ready;
   logic [ttw_pkg::CSR_INDEX_W-1:0] index;
   logic [ttw_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- design/translation_table_walk_classifier.sv -----
// Top level of the translation table walk classifier.
// Depends on ttw_pkg, ttw_if, ttw_csr_regs, ttw_req_stage, ttw_walk_core, ttw_rsp_fifo.
//
//   channel   dir  beat
//   req_bus   in   cmd, descriptor
//   rsp_bus   out  kind, fetch_address, range_start, range_end, range_class,
//                  error_code, walk_done, last
//   csr_bus   in   index, data (always ready)
//
// One request beat per cycle while the result queue has space; a beat is held in the input
// register and decoded combinationally into one or two response beats for the queue.
// Throughput is set by the response port: a beat that yields two records holds it for
// both records. The four-entry result queue lets requests continue while
// responses stall; requests stall once fewer than two entries are free.
// Synchronous reset clears walk state, registers and queue; no clearing pass.
module translation_table_walk_classifier (
   input  logic       clock,
   input  logic       reset,
   ttw_req_if.sink    req_bus,
   ttw_rsp_if.source  rsp_bus,
   ttw_csr_if.sink    csr_bus
);

   ttw_pkg::cfg_type  cfg;
   ttw_pkg::item_type item;
   ttw_pkg::push_type push;
   logic              item_valid;
   logic              take;
   logic              space;

   ttw_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   ttw_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ttw_walk_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .space      (space),
      .take       (take),
      .push       (push)
   );

   ttw_rsp_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .space   (space),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- design/ttw_csr_regs.sv -----
// Configuration registers: table base, granule select, size offset.
// Depends on ttw_pkg and ttw_csr_if.
module ttw_csr_regs (
   input  logic            clock,
   input  logic            reset,
   ttw_csr_if.sink         csr_bus,
   output ttw_pkg::cfg_type cfg
);

   ttw_pkg::cfg_type cfg_ff;
   ttw_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ttw_pkg::CSR_TABLE_BASE:  cfg_in.table_base = csr_bus.data[ttw_pkg::ADDR_W-1:0];
            ttw_pkg::CSR_GRANULE:     cfg_in.granule = csr_bus.data[ttw_pkg::GRANULE_W-1:0];
            ttw_pkg::CSR_SIZE_OFFSET: begin
               cfg_in.size_offset = csr_bus.data[ttw_pkg::SIZE_OFFSET_W-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/ttw_req_stage.sv -----
// Input register for request beats.
// Depends on ttw_pkg and ttw_req_if.
module ttw_req_stage (
   input  logic              clock,
   input  logic              reset,
   ttw_req_if.sink           req_bus,
   input  logic              take,
   output logic              item_valid,
   output ttw_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   ttw_pkg::item_type item_ff;
   logic              accept;

   assign req_bus.ready = !valid_ff || take;
   assign accept = req_bus.valid && req_bus.ready;
   assign item_valid = valid_ff;
   assign item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd <= req_bus.cmd;
         item_ff.descriptor <= req_bus.descriptor;
      end
   end

endmodule

// ----- design/ttw_walk_core.sv -----
// Walk state and per-beat decode: fetch, descend, classify, merge runs, report config errors.
// Depends on ttw_pkg.
module ttw_walk_core (
   input  logic              clock,
   input  logic              reset,
   input  ttw_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  ttw_pkg::item_type item,
   input  logic              space,
   output logic              take,
   output ttw_pkg::push_type push
);

   logic [ttw_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [ttw_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [ttw_pkg::ADDR_W-1:0]  table_ff, table_in;
   logic [ttw_pkg::ADDR_W-1:0]  run_start_ff, run_start_in;
   ttw_pkg::class_type          run_class_ff, run_class_in;
   logic                        walking_ff, walking_in;

   logic [ttw_pkg::ADDR_W-1:0]  base;
   logic [ttw_pkg::ADDR_W-1:0]  step;
   logic [ttw_pkg::ADDR_W-1:0]  next_addr;
   logic [ttw_pkg::ADDR_W-1:0]  new_table;
   logic [ttw_pkg::ADDR_W-1:0]  run_start_new;
   logic [1:0]                  desc_low;
   logic                        descend;
   logic                        ident;
   logic                        changed;
   ttw_pkg::class_type          cls;
   ttw_pkg::rsp_type            tail;

   assign take = item_valid && space;

   always_comb begin
      base = cfg.table_base & ttw_pkg::BASE_MASK & ttw_pkg::PA_MASK;
      step = ttw_pkg::level_step(level_ff);
      next_addr = (addr_ff & ~(step - ttw_pkg::ADDR_W'(1))) + step;
      new_table = item.descriptor[ttw_pkg::ADDR_W-1:0] & ttw_pkg::OA_MASK & ttw_pkg::PA_MASK;
      desc_low = item.descriptor[1:0];
      descend = (desc_low == ttw_pkg::DESC_TABLE) && (level_ff != ttw_pkg::LAST_LEVEL);
      ident = item.descriptor[ttw_pkg::ADDR_W-1:ttw_pkg::PAGE_SHIFT] ==
              addr_ff[ttw_pkg::ADDR_W-1:ttw_pkg::PAGE_SHIFT];
      if ((desc_low == ttw_pkg::DESC_INVALID0) || (desc_low == ttw_pkg::DESC_INVALID2)) begin
         cls = ttw_pkg::CLASS_UNMAPPED;
      end else if (ident) begin
         cls = ttw_pkg::CLASS_IDENTITY;
      end else begin
         cls = ttw_pkg::CLASS_NON_IDENTITY;
      end
      changed = cls != run_class_ff;
      run_start_new = changed ? addr_ff : run_start_ff;
      if (next_addr >= ttw_pkg::WALK_LIMIT) begin
         tail = ttw_pkg::make_range(run_start_new, next_addr, cls, 1'b1);
      end else begin
         tail = ttw_pkg::make_fetch(base, next_addr, ttw_pkg::TOP_LEVEL);
      end
      tail.last = 1'b1;
   end

   always_comb begin
      addr_in = addr_ff;
      level_in = level_ff;
      table_in = table_ff;
      run_start_in = run_start_ff;
      run_class_in = run_class_ff;
      walking_in = walking_ff;
      push = '0;
      if (take) begin
         if (item.cmd == ttw_pkg::CMD_START) begin
            push.first_valid = 1'b1;
            if (cfg.granule != ttw_pkg::GRANULE_4K) begin
               walking_in = 1'b0;
               push.first = ttw_pkg::make_error(ttw_pkg::ERR_GRANULE);
            end else if (cfg.size_offset >= ttw_pkg::SIZE_OFFSET_LIMIT) begin
               walking_in = 1'b0;
               push.first = ttw_pkg::make_error(ttw_pkg::ERR_SIZE_OFFSET);
            end else begin
               walking_in = 1'b1;
               addr_in = '0;
               level_in = ttw_pkg::TOP_LEVEL;
               table_in = base;
               run_start_in = '0;
               run_class_in = ttw_pkg::CLASS_UNMAPPED;
               push.first = ttw_pkg::make_fetch(base, '0, ttw_pkg::TOP_LEVEL);
            end
            push.first.last = 1'b1;
         end else if (walking_ff) begin
            push.first_valid = 1'b1;
            if (descend) begin
               table_in = new_table;
               level_in = level_ff + ttw_pkg::LEVEL_W'(1);
               push.first = ttw_pkg::make_fetch(new_table, addr_ff,
                                                level_ff + ttw_pkg::LEVEL_W'(1));
               push.first.last = 1'b1;
            end else begin
               run_class_in = cls;
               run_start_in = run_start_new;
               addr_in = next_addr;
               level_in = ttw_pkg::TOP_LEVEL;
               table_in = base;
               walking_in = next_addr < ttw_pkg::WALK_LIMIT;
               // no record for a class change at address zero
               if (changed && (addr_ff != '0)) begin
                  push.first = ttw_pkg::make_range(run_start_ff, addr_ff, run_class_ff, 1'b0);
                  push.second_valid = 1'b1;
                  push.second = tail;
               end else begin
                  push.first = tail;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         level_ff <= ttw_pkg::TOP_LEVEL;
         table_ff <= '0;
         run_start_ff <= '0;
         run_class_ff <= ttw_pkg::CLASS_UNMAPPED;
         walking_ff <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         level_ff <= level_in;
         table_ff <= table_in;
         run_start_ff <= run_start_in;
         run_class_ff <= run_class_in;
         walking_ff <= walking_in;
      end
   end

endmodule

// ----- design/ttw_rsp_fifo.sv -----
// Result queue: takes up to two beats a cycle, drives the response channel.
// Depends on ttw_pkg and ttw_rsp_if.
module ttw_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ttw_pkg::push_type push,
   output logic              space,
   ttw_rsp_if.source         rsp_bus
);

   ttw_pkg::rsp_type                entry_ff [ttw_pkg::FIFO_DEPTH];
   logic [ttw_pkg::FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ttw_pkg::FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [ttw_pkg::FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [ttw_pkg::FIFO_PTR_W-1:0]  wr_ptr_next;
   logic [ttw_pkg::FIFO_CNT_W-1:0]  push_count;
   logic                            pop;
   ttw_pkg::rsp_type                head;

   assign space = count_ff <= ttw_pkg::FIFO_CNT_W'(ttw_pkg::FIFO_DEPTH - 2);
   assign pop = rsp_bus.valid && rsp_bus.ready;
   assign wr_ptr_next = wr_ptr_ff + ttw_pkg::FIFO_PTR_W'(1);
   assign push_count = ttw_pkg::FIFO_CNT_W'(push.first_valid) +
                       ttw_pkg::FIFO_CNT_W'(push.second_valid);
   assign head = entry_ff[rd_ptr_ff];

   assign rsp_bus.valid = count_ff != '0;
   assign rsp_bus.kind = head.kind;
   assign rsp_bus.fetch_address = head.fetch_address;
   assign rsp_bus.range_start = head.range_start;
   assign rsp_bus.range_end = head.range_end;
   assign rsp_bus.range_class = head.range_class;
   assign rsp_bus.error_code = head.error_code;
   assign rsp_bus.walk_done = head.walk_done;
   assign rsp_bus.last = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + ttw_pkg::FIFO_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + ttw_pkg::FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + push_count - ttw_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

// ----- design/ttw_checker.sv -----
// Port-level checks on the response channel, bound to the top level.
// Depends on ttw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ttw_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_kind,
   input logic [ttw_pkg::ADDR_W-1:0] rsp_fetch_address,
   input logic [ttw_pkg::ADDR_W-1:0] rsp_range_start,
   input logic [ttw_pkg::ADDR_W-1:0] rsp_range_end,
   input logic                       rsp_walk_done,
   input logic                       rsp_last
);

   `TTW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fetch_address) && $stable(rsp_range_end), "response beat changed while stalled")

   `TTW_ASSERT_IMPLY(a_error_last, clock, reset, rsp_valid && (rsp_kind == ttw_pkg::KIND_ERROR), rsp_last && !rsp_walk_done, "error beat not a lone last beat")

   `TTW_ASSERT_IMPLY(a_done_range, clock, reset, rsp_valid && rsp_walk_done, (rsp_kind == ttw_pkg::KIND_RANGE) && rsp_last, "walk done outside a final range beat")

   `TTW_ASSERT_IMPLY(a_range_order, clock, reset, rsp_valid && (rsp_kind == ttw_pkg::KIND_RANGE), rsp_range_start < rsp_range_end, "empty or reversed range")

   `TTW_ASSERT_IMPLY(a_fetch_clean, clock, reset, rsp_valid && (rsp_kind == ttw_pkg::KIND_FETCH), (rsp_range_start == '0) && (rsp_range_end == '0) && rsp_last, "fetch beat carries range fields")

endmodule

bind translation_table_walk_classifier ttw_checker u_ttw_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_kind          (rsp_bus.kind),
   .rsp_fetch_address (rsp_bus.fetch_address),
   .rsp_range_start   (rsp_bus.range_start),
   .rsp_range_end     (rsp_bus.range_end),
   .rsp_walk_done     (rsp_bus.walk_done),
   .rsp_last          (rsp_bus.last)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the translation table walk classifier.
// Feeds start and descriptor beats, predicts fetch, range and error beats, checks each one.
// Depends on ttw_pkg, the channel interfaces in ttw_if and the block itself.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS  = 450;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int MAX_GAP       = 17;
   localparam int PLAN_ROWS     = 26;

   typedef enum logic [0:0] {
      ROW_ITEM = 1'b0,
      ROW_CSR  = 1'b1
   } row_op_type;

   typedef struct packed {
      row_op_type                         op;
      ttw_pkg::cmd_type                   cmd;
      logic [ttw_pkg::DESC_W-1:0]         descriptor;
      ttw_pkg::csr_index_type             csr_index;
      logic [ttw_pkg::ADDR_W-1:0]         csr_data;
      logic                               check_literal;
      ttw_pkg::kind_type                  lit_kind;
      logic [ttw_pkg::ADDR_W-1:0]         lit_fetch;
      ttw_pkg::err_type                   lit_error;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'hffff_ffff_ffff_ffff, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_GRANULE, 48'h3,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_ERROR, 48'h0, ttw_pkg::ERR_GRANULE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_SIZE_OFFSET, 48'h3f,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_ERROR, 48'h0, ttw_pkg::ERR_GRANULE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_GRANULE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_ERROR, 48'h0, ttw_pkg::ERR_SIZE_OFFSET},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_SIZE_OFFSET, 48'd25,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_ERROR, 48'h0, ttw_pkg::ERR_SIZE_OFFSET},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_SIZE_OFFSET, 48'd24,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'hffff_ffff_ffff,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_FETCH, 48'hffff_ffff_fffe, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'hffff_ffff_ffff_ffff, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h3, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h0000_0080_4000_0003, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h0000_0080_0000_0003, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h1, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h2, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'hffff_0000_0000_0ffd, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b1, ttw_pkg::KIND_FETCH, 48'hffff_ffff_fffe, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h1, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_CSR,  ttw_pkg::CMD_START, 64'h0, ttw_pkg::CSR_SIZE_OFFSET, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h1, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE},
      '{ROW_ITEM, ttw_pkg::CMD_DESC,  64'h0000_0100_0000_0001, ttw_pkg::CSR_TABLE_BASE, 48'h0,
        1'b0, ttw_pkg::KIND_FETCH, 48'h0, ttw_pkg::ERR_NONE}
   };

   logic clock = 1'b0;
   logic reset;

   ttw_req_if req_bus();
   ttw_rsp_if rsp_bus();
   ttw_csr_if csr_bus();

   translation_table_walk_classifier u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ttw_pkg::cfg_type              walk_cfg;
   logic [ttw_pkg::ADDR_W-1:0]    walk_addr;
   logic [ttw_pkg::ADDR_W-1:0]    table_addr;
   logic [ttw_pkg::ADDR_W-1:0]    run_begin;
   logic [ttw_pkg::LEVEL_W-1:0]   walk_lvl;
   ttw_pkg::class_type            run_cls;
   logic                          walk_busy;
   ttw_pkg::rsp_type              walk_outcome[$];
   ttw_pkg::rsp_type              expected_rsps[$];
   int                            fail_count  = 0;
   int                            stall_count = 0;
   int                            leaf_mode   = 0;
   logic                          send_quiet  = 1'b0;
   logic                          take_quiet  = 1'b0;

   function automatic int level_shift_of(logic [ttw_pkg::LEVEL_W-1:0] lvl);
      return ttw_pkg::TOP_SHIFT - ttw_pkg::LEVEL_STRIDE * int'(lvl);
   endfunction

   function automatic logic [ttw_pkg::ADDR_W-1:0] tables_root();
      return walk_cfg.table_base & ttw_pkg::BASE_MASK & ttw_pkg::PA_MASK;
   endfunction

   task automatic queue_fetch();
      logic [ttw_pkg::INDEX_W-1:0] idx;
      ttw_pkg::rsp_type r;
      idx = ttw_pkg::INDEX_W'(walk_addr >> level_shift_of(walk_lvl));
      r = '0;
      r.kind = ttw_pkg::KIND_FETCH;
      r.fetch_address = table_addr + {36'd0, idx, 3'b000};
      walk_outcome.push_back(r);
   endtask

   task automatic queue_range(logic done);
      ttw_pkg::rsp_type r;
      r = '0;
      r.kind = ttw_pkg::KIND_RANGE;
      r.range_start = run_begin;
      r.range_end = walk_addr;
      r.range_class = run_cls;
      r.walk_done = done;
      walk_outcome.push_back(r);
   endtask

   task automatic predict_walk(ttw_pkg::cmd_type cmd, logic [ttw_pkg::DESC_W-1:0] d);
      ttw_pkg::class_type cls;
      ttw_pkg::rsp_type r;
      int sh;
      walk_outcome.delete();
      if (cmd == ttw_pkg::CMD_START) begin
         if (walk_cfg.granule != ttw_pkg::GRANULE_4K ||
             walk_cfg.size_offset >= ttw_pkg::SIZE_OFFSET_LIMIT) begin
            walk_busy = 1'b0;
            r = '0;
            r.kind = ttw_pkg::KIND_ERROR;
            r.error_code = (walk_cfg.granule != ttw_pkg::GRANULE_4K) ? ttw_pkg::ERR_GRANULE
                                                                      : ttw_pkg::ERR_SIZE_OFFSET;
            walk_outcome.push_back(r);
         end else begin
            walk_busy = 1'b1;
            walk_addr = '0;
            walk_lvl = ttw_pkg::TOP_LEVEL;
            table_addr = tables_root();
            run_begin = '0;
            run_cls = ttw_pkg::CLASS_UNMAPPED;
            queue_fetch();
         end
      end else if (walk_busy) begin
         sh = level_shift_of(walk_lvl);
         if (d[1:0] == ttw_pkg::DESC_TABLE && walk_lvl < ttw_pkg::LAST_LEVEL) begin
            table_addr = d[ttw_pkg::ADDR_W-1:0] & ttw_pkg::OA_MASK & ttw_pkg::PA_MASK;
            walk_lvl++;
            queue_fetch();
         end else begin
            if (d[1:0] == ttw_pkg::DESC_INVALID0 || d[1:0] == ttw_pkg::DESC_INVALID2)
               cls = ttw_pkg::CLASS_UNMAPPED;
            else if ((d[ttw_pkg::ADDR_W-1:0] & ttw_pkg::OA_MASK) ==
                     (walk_addr & ttw_pkg::OA_MASK))
               cls = ttw_pkg::CLASS_IDENTITY;
            else
               cls = ttw_pkg::CLASS_NON_IDENTITY;
            // no record for a class change at address zero
            if (cls != run_cls) begin
               if (walk_addr != '0)
                  queue_range(1'b0);
               run_cls = cls;
               run_begin = walk_addr;
            end
            walk_addr = ((walk_addr >> sh) + 48'd1) << sh;
            walk_lvl = ttw_pkg::TOP_LEVEL;
            table_addr = tables_root();
            if (walk_addr >= ttw_pkg::WALK_LIMIT) begin
               queue_range(1'b1);
               walk_busy = 1'b0;
            end else begin
               queue_fetch();
            end
         end
      end
      if (walk_outcome.size() != 0) begin
         r = walk_outcome.pop_back();
         r.last = 1'b1;
         walk_outcome.push_back(r);
      end
   endtask

   task automatic push_req(ttw_pkg::cmd_type cmd, logic [ttw_pkg::DESC_W-1:0] d,
                           logic use_literal, ttw_pkg::rsp_type literal);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.cmd <= cmd;
      req_bus.descriptor <= d;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_walk(cmd, d);
      if (use_literal)
         expected_rsps.push_back(literal);
      else
         foreach (walk_outcome[i]) expected_rsps.push_back(walk_outcome[i]);
      if ($urandom_range(0, 39) == 0)
         send_quiet = !send_quiet;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(ttw_pkg::csr_index_type idx,
                            logic [ttw_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         ttw_pkg::CSR_TABLE_BASE:  walk_cfg.table_base = value;
         ttw_pkg::CSR_GRANULE:     walk_cfg.granule = value[ttw_pkg::GRANULE_W-1:0];
         ttw_pkg::CSR_SIZE_OFFSET: walk_cfg.size_offset = value[ttw_pkg::SIZE_OFFSET_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [ttw_pkg::ADDR_W-1:0] random_base();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return ttw_pkg::ADDR_W'({$urandom, $urandom});
      endcase
   endfunction

   task automatic shuffle_config();
      logic [ttw_pkg::CSR_DATA_W-1:0] v;
      settle_block();
      if ($urandom_range(0, 1))
         write_csr(ttw_pkg::CSR_TABLE_BASE, random_base());
      if ($urandom_range(0, 1)) begin
         v = ttw_pkg::CSR_DATA_W'({$urandom, $urandom});
         v[1:0] = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : ttw_pkg::GRANULE_4K;
         write_csr(ttw_pkg::CSR_GRANULE, v);
      end
      if ($urandom_range(0, 1)) begin
         v = ttw_pkg::CSR_DATA_W'({$urandom, $urandom});
         v[5:0] = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(25, 63))
                                               : 6'($urandom_range(0, 24));
         write_csr(ttw_pkg::CSR_SIZE_OFFSET, v);
      end
   endtask

   // mostly top-level leaves so a walk reaches its end; class tends to repeat into runs
   function automatic logic [ttw_pkg::DESC_W-1:0] next_descriptor();
      logic [ttw_pkg::DESC_W-1:0] d;
      int descend_pct;
      d = {$urandom, $urandom};
      descend_pct = (walk_lvl == ttw_pkg::TOP_LEVEL) ? 10 : 30;
      if (walk_lvl < ttw_pkg::LAST_LEVEL && $urandom_range(0, 99) < descend_pct) begin
         d[1:0] = ttw_pkg::DESC_TABLE;
         return d;
      end
      if ($urandom_range(0, 99) < 30)
         leaf_mode = $urandom_range(0, 2);
      case (leaf_mode)
         0: d[1:0] = $urandom_range(0, 1) ? ttw_pkg::DESC_INVALID2 : ttw_pkg::DESC_INVALID0;
         1: d[1:0] = (walk_lvl == ttw_pkg::LAST_LEVEL && $urandom_range(0, 1)) ?
                     ttw_pkg::DESC_TABLE : ttw_pkg::DESC_BLOCK;
         default: begin
            d[47:12] = walk_addr[47:12];
            d[1:0] = (walk_lvl == ttw_pkg::LAST_LEVEL && $urandom_range(0, 1)) ?
                     ttw_pkg::DESC_TABLE : ttw_pkg::DESC_BLOCK;
         end
      endcase
      return d;
   endfunction

   task automatic compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         $display("%0t: %s expected %h got %h", $time, name, want_v, got_v);
      end
   endtask

   initial begin
      int gap;
      ttw_pkg::rsp_type want;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         gap = take_quiet ? 0 : $urandom_range(0, MAX_GAP);
         repeat (gap) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_rsps.size() == 0) begin
            fail_count++;
            $display("%0t: beat with nothing expected, expected none got kind %0d",
                     $time, rsp_bus.kind);
         end else begin
            want = expected_rsps.pop_front();
            compare_field("kind", want.kind, rsp_bus.kind);
            compare_field("fetch_address", want.fetch_address, rsp_bus.fetch_address);
            compare_field("range_start", want.range_start, rsp_bus.range_start);
            compare_field("range_end", want.range_end, rsp_bus.range_end);
            compare_field("range_class", want.range_class, rsp_bus.range_class);
            compare_field("error_code", want.error_code, rsp_bus.error_code);
            compare_field("walk_done", want.walk_done, rsp_bus.walk_done);
            compare_field("last", want.last, rsp_bus.last);
         end
         if ($urandom_range(0, 39) == 0)
            take_quiet = !take_quiet;
      end
   end

   initial begin
      while (stall_count < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            stall_count = 0;
         else
            stall_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int sent;
      ttw_pkg::rsp_type literal;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = ttw_pkg::CMD_START;
      req_bus.descriptor = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = ttw_pkg::CSR_TABLE_BASE;
      csr_bus.data = '0;
      walk_cfg = '0;
      walk_addr = '0;
      table_addr = '0;
      run_begin = '0;
      walk_lvl = ttw_pkg::TOP_LEVEL;
      run_cls = ttw_pkg::CLASS_UNMAPPED;
      walk_busy = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].op == ROW_CSR) begin
            settle_block();
            write_csr(plan[i].csr_index, plan[i].csr_data);
         end else begin
            literal = '0;
            literal.kind = plan[i].lit_kind;
            literal.fetch_address = plan[i].lit_fetch;
            literal.error_code = plan[i].lit_error;
            literal.last = 1'b1;
            push_req(plan[i].cmd, plan[i].descriptor, plan[i].check_literal, literal);
         end
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (!walk_busy) begin
            if ($urandom_range(0, 3) == 0) begin
               push_req(ttw_pkg::CMD_DESC, {$urandom, $urandom}, 1'b0, '0);
            end else begin
               if ($urandom_range(0, 1))
                  shuffle_config();
               push_req(ttw_pkg::CMD_START, {$urandom, $urandom}, 1'b0, '0);
            end
            sent++;
         end else if ($urandom_range(0, 599) == 0) begin
            if ($urandom_range(0, 1))
               shuffle_config();
            push_req(ttw_pkg::CMD_START, {$urandom, $urandom}, 1'b0, '0);
            sent++;
         end else if ($urandom_range(0, 79) == 0) begin
            // new table base while a walk is in flight
            settle_block();
            write_csr(ttw_pkg::CSR_TABLE_BASE, random_base());
         end else begin
            push_req(ttw_pkg::CMD_DESC, next_descriptor(), 1'b0, '0);
            sent++;
         end
      end

      settle_block();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
